[rtl/tslru_pkg.sv]
// Shared types and constants for the timestamp LRU block.
// No dependencies; imported by the store, the min unit, the top level and the testbench.
package tslru_pkg;

  localparam int STAMP_W = 64;

  typedef logic [STAMP_W-1:0] stamp_t;

  // request opcodes (the unused code behaves as a query)
  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_ACCESS = 2'd2;

endpackage

[rtl/timestamp_lru_with_eager_mark.sv]
// Top level of the timestamp LRU replacement block with eager LRU mark.
// Depends on tslru_pkg, tslru_store and tslru_min.
//
// One request is handled at a time. After acceptance the set row arrives and
// the stamp is applied (S_LOAD), the shared min-search unit reduces the stamps
// level by level (S_REDUCE), and a final state (S_DONE) writes the row back if
// it was stamped and loads the result, waiting there while the output register
// holds a result not yet taken. in_ready returns the cycle after the result is
// loaded. The next request is taken while a result still waits in the output
// register. After reset the block clears the state memory, one set a cycle,
// before in_ready rises. The set's mark is kept as a single way number per set,
// since a re-mark always leaves exactly the LRU way marked.
module timestamp_lru_with_eager_mark
  import tslru_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [5:0] set_index,
  input  logic [3:0] way_index,
  input  logic       hit,
  input  logic       write_access,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] victim_way,
  output logic [3:0] marked_way,
  output logic       marked_valid,
  output logic       updated
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = $clog2(WAYS);
  localparam int ROW_W = WAYS * STAMP_W + WAY_W + 1;
  localparam logic [5:0] WAYS_LIM = 6'(WAYS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [SET_W-1:0]            clr_addr;
  stamp_t                      counter;
  logic [SET_W-1:0]            set_q;
  logic [WAY_W-1:0]            way_q;
  logic                        stamp_q;
  logic [WAYS-1:0][STAMP_W-1:0] stamps_q;
  logic [WAYS-1:0][STAMP_W-1:0] stamps_new;
  logic                        mvalid_q;
  logic [WAY_W-1:0]            mway_q;
  logic [WAY_W-1:0]            victim_q;

  logic [SET_W-1:0]            set_mod;
  logic                        accept;
  logic                        stamp_in;
  logic                        out_free;
  logic                        mem_rd_en;
  logic                        mem_wr_en;
  logic [SET_W-1:0]            mem_wr_addr;
  logic [ROW_W-1:0]            mem_wr_data;
  logic [ROW_W-1:0]            mem_rd_data;
  logic                        min_start;
  logic                        min_done;
  logic [WAY_W-1:0]            min_way;

  // set index modulo SETS: restoring subtract, one shifted step per bit
  generate
    if (SETS >= 64) begin : g_set_wide
      assign set_mod = SET_W'(set_index);
    end else begin : g_set_mod
      always_comb begin
        int r;
        r = int'(set_index);
        for (int k = 5; k >= 0; k--) begin
          if (r >= (SETS << k)) begin
            r = r - (SETS << k);
          end
        end
        set_mod = SET_W'(r);
      end
    end
  endgenerate

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign stamp_in = ((operation == OP_FILL) ||
                     ((operation == OP_ACCESS) && hit && !write_access)) &&
                    ({2'b00, way_index} < WAYS_LIM);

  // apply the stamp to the row just read
  always_comb begin
    stamps_new = mem_rd_data[WAYS*STAMP_W-1:0];
    if (stamp_q) begin
      stamps_new[way_q] = counter;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == SET_W'(SETS - 1)) state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = S_LOAD;
      S_LOAD:   state_next = S_REDUCE;
      S_REDUCE: if (min_done) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  assign mem_rd_en   = accept;
  assign min_start   = (state == S_LOAD);
  assign mem_wr_en   = (state == S_CLEAR) || ((state == S_DONE) && stamp_q);
  assign mem_wr_addr = (state == S_CLEAR) ? clr_addr : set_q;
  assign mem_wr_data = (state == S_CLEAR) ? '0 : {1'b1, victim_q, stamps_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if ((state == S_LOAD) && stamp_q) begin
        counter <= counter + 1'b1;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q   <= set_mod;
      way_q   <= WAY_W'(way_index);
      stamp_q <= stamp_in;
    end
    if (state == S_LOAD) begin
      stamps_q <= stamps_new;
      mvalid_q <= mem_rd_data[ROW_W-1];
      mway_q   <= mem_rd_data[ROW_W-2 -: WAY_W];
    end
    if ((state == S_REDUCE) && min_done) begin
      victim_q <= min_way;
    end
    if ((state == S_DONE) && out_free) begin
      victim_way   <= 4'(victim_q);
      marked_way   <= stamp_q ? 4'(victim_q) : 4'(mway_q);
      marked_valid <= stamp_q || mvalid_q;
      updated      <= stamp_q;
    end
  end

  tslru_store #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (set_mod),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  tslru_min #(
    .WAYS (WAYS)
  ) u_min (
    .clk     (clk),
    .rst     (rst),
    .start   (min_start),
    .stamps  (stamps_new),
    .done    (min_done),
    .min_way (min_way)
  );

endmodule

[rtl/tslru_store.sv]
// Per-set state memory: one row per set holding the mark and all way stamps.
// Depends on tslru_pkg. One write port, one read port, registered read data.
module tslru_store
  import tslru_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 16
) (
  input  logic                                       clk,
  input  logic                                       rd_en,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0]   rd_addr,
  output logic [WAYS*STAMP_W+$clog2(WAYS):0]         rd_data,
  input  logic                                       wr_en,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0]   wr_addr,
  input  logic [WAYS*STAMP_W+$clog2(WAYS):0]         wr_data
);

  localparam int ROW_W = WAYS * STAMP_W + $clog2(WAYS) + 1;

  logic [ROW_W-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/tslru_min.sv]
// Iterative minimum search over the stamps of one set, one tree level a cycle.
// Depends on tslru_pkg. Ties resolve to the lower way; padding slots never win.
module tslru_min
  import tslru_pkg::*;
#(
  parameter int WAYS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [WAYS-1:0][STAMP_W-1:0]      stamps,
  output logic                              done,
  output logic [$clog2(WAYS)-1:0]           min_way
);

  localparam int WAY_W = $clog2(WAYS);
  localparam int PAD   = 2 ** WAY_W;
  localparam int LVL   = WAY_W;
  localparam int LVL_W = $clog2(LVL + 1);

  stamp_t             cand_stamp [PAD];
  logic [WAY_W-1:0]   cand_way   [PAD];
  logic               busy;
  logic [LVL_W-1:0]   lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      lvl  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        lvl  <= '0;
      end else if (busy) begin
        if (lvl == LVL_W'(LVL - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        lvl <= lvl + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < PAD; i++) begin
        cand_stamp[i] <= (i < WAYS) ? stamps[i] : '1;
        cand_way[i]   <= WAY_W'(i);
      end
    end else if (busy) begin
      // pairwise reduce; left (lower way) keeps ties
      for (int i = 0; i < PAD / 2; i++) begin
        if (cand_stamp[2*i+1] < cand_stamp[2*i]) begin
          cand_stamp[i] <= cand_stamp[2*i+1];
          cand_way[i]   <= cand_way[2*i+1];
        end else begin
          cand_stamp[i] <= cand_stamp[2*i];
          cand_way[i]   <= cand_way[2*i];
        end
      end
    end
  end

  assign min_way = cand_way[0];

endmodule

[rtl/tslru_checker.sv]
// Port-level checks for the timestamp LRU block, attached by bind.
// Depends only on the top level's ports.
module tslru_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] victim_way,
  input logic [3:0] marked_way,
  input logic       marked_valid,
  input logic       updated
);

  // reset starts the clearing pass: no input taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block not quiet after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(victim_way) &&
      $stable(marked_way) && $stable(marked_valid) && $stable(updated))
    else $error("result changed while stalled");

  // a re-mark always leaves the victim way marked
  a_mark_is_victim: assert property (@(posedge clk) disable iff (rst)
    out_valid && updated |-> marked_valid && (marked_way == victim_way))
    else $error("updated set not marked at its victim way");

  // an unmarked set reports way zero
  a_unmarked_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !marked_valid |-> (marked_way == 4'd0))
    else $error("unmarked set reports a way");

endmodule

bind timestamp_lru_with_eager_mark tslru_checker u_checker (.*);

[tb/timestamp_lru_with_eager_mark_tb.sv]
// Self-checking testbench for timestamp_lru_with_eager_mark: directed table, then random requests,
// each checked against a behavioral LRU model kept in this file or a fixed row's typed-in result.
// Depends on tslru_pkg and the timestamp_lru_with_eager_mark RTL.
module timestamp_lru_with_eager_mark_tb;
  import tslru_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 16;
  localparam int RAND_ITEMS = 1700;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [3:0] marked_way;
    logic       marked_valid;
    logic       updated;
  } lru_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  set_no;
    logic [3:0]  way_no;
    logic        hit_f;
    logic        wr_f;
    logic        fixed;   // expectation typed in below instead of taken from the model
    lru_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_QUERY,  6'd0,  4'd0,  1'b0, 1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{OP_ACCESS, 6'd5,  4'd3,  1'b0, 1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{OP_ACCESS, 6'd6,  4'd2,  1'b1, 1'b1, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{OP_UNUSED, 6'd7,  4'd9,  1'b1, 1'b0, 1'b1, '{4'd0, 4'd0, 1'b0, 1'b0}},
    '{OP_FILL,   6'd0,  4'd0,  1'b0, 1'b0, 1'b1, '{4'd0, 4'd0, 1'b1, 1'b1}},
    '{OP_FILL,   6'd0,  4'd15, 1'b1, 1'b1, 1'b0, '0},
    '{OP_FILL,   6'd0,  4'd1,  1'b0, 1'b1, 1'b0, '0},
    '{OP_ACCESS, 6'd0,  4'd0,  1'b1, 1'b0, 1'b0, '0},
    '{OP_QUERY,  6'd0,  4'd7,  1'b1, 1'b1, 1'b0, '0},
    '{OP_FILL,   6'd63, 4'd15, 1'b0, 1'b0, 1'b0, '0},
    '{OP_ACCESS, 6'd63, 4'd15, 1'b1, 1'b0, 1'b0, '0},
    '{OP_ACCESS, 6'd63, 4'd0,  1'b0, 1'b1, 1'b0, '0},
    '{OP_ACCESS, 6'd63, 4'd0,  1'b1, 1'b1, 1'b0, '0},
    '{OP_UNUSED, 6'd63, 4'd15, 1'b0, 1'b0, 1'b0, '0},
    '{OP_FILL,   6'd42, 4'd10, 1'b1, 1'b0, 1'b0, '0},
    '{OP_FILL,   6'd42, 4'd5,  1'b0, 1'b1, 1'b0, '0},
    '{OP_ACCESS, 6'd42, 4'd10, 1'b1, 1'b0, 1'b0, '0},
    '{OP_QUERY,  6'd42, 4'd0,  1'b0, 1'b0, 1'b0, '0},
    '{OP_FILL,   6'd21, 4'd15, 1'b0, 1'b0, 1'b0, '0},
    '{OP_QUERY,  6'd21, 4'd15, 1'b0, 1'b0, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  logic [5:0] set_index;
  logic [3:0] way_index;
  logic       hit;
  logic       write_access;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] victim_way;
  logic [3:0] marked_way;
  logic       marked_valid;
  logic       updated;

  timestamp_lru_with_eager_mark #(.SETS(NSETS), .WAYS(NWAYS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .set_index    (set_index),
    .way_index    (way_index),
    .hit          (hit),
    .write_access (write_access),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .victim_way   (victim_way),
    .marked_way   (marked_way),
    .marked_valid (marked_valid),
    .updated      (updated)
  );

  always #10 clk = ~clk;

  // LRU model state
  stamp_t     use_stamp [NSETS][NWAYS];
  stamp_t     use_count;
  logic [3:0] mark_way [NSETS];
  logic       mark_on [NSETS];

  lru_result_t pending_results [$];
  int  fail_count = 0;
  bit  no_idle = 1'b0;
  bit  hold_out = 1'b0;

  function automatic logic [3:0] oldest_way(input int s);
    int best;
    int w;
    best = 0;
    for (w = 1; w < NWAYS; w++)
      if (use_stamp[s][w] < use_stamp[s][best]) best = w;
    return best[3:0];
  endfunction

  function automatic lru_result_t apply_request(input logic [1:0] op, input logic [5:0] set_no,
                                                input logic [3:0] way_no, input logic hit_f,
                                                input logic wr_f);
    lru_result_t r;
    int s;
    logic stamp_it;
    s = int'(set_no) % NSETS;
    stamp_it = (op == OP_FILL) || (op == OP_ACCESS && hit_f && !wr_f);
    if (int'(way_no) >= NWAYS) stamp_it = 1'b0;
    if (stamp_it) begin
      use_stamp[s][way_no] = use_count;
      use_count = use_count + 1'b1;
      // re-mark: only the current LRU way keeps the mark
      mark_way[s] = oldest_way(s);
      mark_on[s] = 1'b1;
    end
    r.victim_way   = oldest_way(s);
    r.marked_way   = mark_on[s] ? mark_way[s] : 4'd0;
    r.marked_valid = mark_on[s];
    r.updated      = stamp_it;
    return r;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item, wait for it to be taken, then record what it should produce.
  task automatic send_item(input logic [1:0] op, input logic [5:0] set_no, input logic [3:0] way_no,
                           input logic hit_f, input logic wr_f, input logic fixed,
                           input lru_result_t fixed_res, input int gap);
    lru_result_t r;
    in_valid     <= 1'b1;
    operation    <= op;
    set_index    <= set_no;
    way_index    <= way_no;
    hit          <= hit_f;
    write_access <= wr_f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_request(op, set_no, way_no, hit_f, wr_f);
    pending_results.push_back(fixed ? fixed_res : r);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls, an occasional long one, a forced long hold on request
  initial begin : sink
    int len;
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        len = 300;
      end else if (no_idle) begin
        len = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        len = $urandom_range(20, 80);
      end else begin
        len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
      end
      if (len > 0) begin
        out_ready <= 1'b0;
        repeat (len) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    lru_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: victim %0d marked %0d/%0b updated %0b",
                   victim_way, marked_way, marked_valid, updated);
      end else begin
        want = pending_results.pop_front();
        if (victim_way !== want.victim_way || marked_way !== want.marked_way ||
            marked_valid !== want.marked_valid || updated !== want.updated) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: victim %0d/%0d marked %0d/%0d valid %0b/%0b updated %0b/%0b",
                     want.victim_way, victim_way, want.marked_way, marked_way,
                     want.marked_valid, marked_valid, want.updated, updated);
        end
      end
    end
  end

  initial begin : watchdog
    #(20 * 2000000);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int i;
    int s;
    int w;
    int r;
    int gap;
    logic [1:0] op;
    logic [5:0] set_no;
    logic [5:0] hot_sets [3];
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    operation    <= OP_QUERY;
    set_index    <= '0;
    way_index    <= '0;
    hit          <= 1'b0;
    write_access <= 1'b0;
    for (s = 0; s < NSETS; s++) begin
      for (w = 0; w < NWAYS; w++) use_stamp[s][w] = '0;
      mark_way[s] = '0;
      mark_on[s] = 1'b0;
    end
    use_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].op, dir_rows[i].set_no, dir_rows[i].way_no, dir_rows[i].hit_f,
                dir_rows[i].wr_f, dir_rows[i].fixed, dir_rows[i].res, next_gap());

    // most traffic hits a few sets so every way gets stamped and the LRU order churns
    for (i = 0; i < 3; i++) hot_sets[i] = 6'($urandom_range(0, NSETS - 1));
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) no_idle = 1'b1;
      if (i == 500) no_idle = 1'b0;
      if (i == 800) hold_out = 1'b1;
      if (i == 1200) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 8) op = OP_QUERY;
      else if (r < 11) op = OP_UNUSED;
      else if (r < 50) op = OP_FILL;
      else op = OP_ACCESS;
      set_no = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 2)]
                                           : 6'($urandom_range(0, NSETS - 1));
      gap = (i == RAND_ITEMS - 1) ? 1 : next_gap();
      if (i >= 800 && i < 840) gap = 0;
      send_item(op, set_no, 4'($urandom_range(0, 15)), ($urandom_range(0, 99) < 85),
                ($urandom_range(0, 99) < 15), 1'b0, '0, gap);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tslru_pkg.sv
rtl/tslru_store.sv
rtl/tslru_min.sv
rtl/timestamp_lru_with_eager_mark.sv
rtl/tslru_checker.sv
tb/timestamp_lru_with_eager_mark_tb.sv
